/* design/bvfg_pkg.sv */
// Shared types, constants and the charge curve for the battery voltage filter gauge.
// No dependencies; imported by every module of the block.
package bvfg_pkg;

  // burst and ring geometry
  localparam int SAMPLES_PER_BURST = 16;
  localparam int HISTORY_DEPTH     = 8;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 14;
  localparam int MV_W     = 13;
  localparam int PCT_W    = 7;
  localparam int BSUM_W   = 20;
  localparam int BCNT_W   = 8;
  localparam int PROD_W   = SCALE_W + SAMPLE_W;
  localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LEN_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int ACC_W    = MV_W + LEN_W;

  // millivolt thresholds
  localparam logic [MV_W-1:0]    CHARGER_MV    = 13'd4250;
  localparam logic [MV_W-1:0]    FULL_MV       = 13'd4200;
  localparam logic [MV_W-1:0]    HYST_MV       = 13'd50;
  localparam logic [SCALE_W-1:0] ADC_SCALE_RST = 14'd6600;
  localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;

  // reciprocals scaled by 2^16, exact for the segment offsets used below
  localparam logic [13:0] RECIP_5  = 14'd13108;
  localparam logic [13:0] RECIP_7  = 14'd9363;
  localparam logic [13:0] RECIP_10 = 14'd6554;
  localparam logic [13:0] RECIP_14 = 14'd4682;
  localparam logic [13:0] RECIP_25 = 14'd2622;
  localparam logic [13:0] RECIP_75 = 14'd874;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [MV_W-1:0]  reported_mv;
    logic [PCT_W-1:0] percent;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic scale;
    logic store;
    logic sum_step;
    logic div_start;
    logic hyst;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic burst_last;
    logic prime;
    logic sum_last;
    logic div_busy;
    logic out_free;
  } status_t;

  // piecewise lipo discharge curve, one segment offset times a reciprocal
  function automatic logic [PCT_W-1:0] lipo_percent(input logic [MV_W-1:0] mv);
    logic [8:0]       d;
    logic [13:0]      m;
    logic [PCT_W-1:0] base;
    logic [22:0]      p;
    d    = '0;
    m    = '0;
    base = '0;
    if (mv >= 13'd4200) begin
      base = PCT_FULL;
    end else if (mv >= 13'd4100) begin
      base = 7'd90; d = 9'(mv - 13'd4100); m = RECIP_10;
    end else if (mv >= 13'd4000) begin
      base = 7'd80; d = 9'(mv - 13'd4000); m = RECIP_10;
    end else if (mv >= 13'd3900) begin
      base = 7'd70; d = 9'(mv - 13'd3900); m = RECIP_10;
    end else if (mv >= 13'd3800) begin
      base = 7'd60; d = 9'(mv - 13'd3800); m = RECIP_10;
    end else if (mv >= 13'd3700) begin
      base = 7'd40; d = 9'(mv - 13'd3700); m = RECIP_5;
    end else if (mv >= 13'd3600) begin
      base = 7'd25; d = 9'(mv - 13'd3600); m = RECIP_7;
    end else if (mv >= 13'd3500) begin
      base = 7'd15; d = 9'(mv - 13'd3500); m = RECIP_10;
    end else if (mv >= 13'd3400) begin
      base = 7'd8;  d = 9'(mv - 13'd3400); m = RECIP_14;
    end else if (mv >= 13'd3300) begin
      base = 7'd4;  d = 9'(mv - 13'd3300); m = RECIP_25;
    end else if (mv >= 13'd3000) begin
      base = 7'd0;  d = 9'(mv - 13'd3000); m = RECIP_75;
    end
    p = {14'd0, d} * {9'd0, m};
    return base + p[22:16];
  endfunction

endpackage

/* design/battery_voltage_filter_gauge.sv */
// Battery voltage filter and LiPo charge gauge, top level.
// Depends on bvfg_pkg, bvfg_ctrl, bvfg_datapath (which holds bvfg_div).
//
// Samples are taken one per cycle while the block is idle. The last sample of
// each burst of SAMPLES_PER_BURST starts the burst end work: scale, store into
// the ring, sum the filled ring entries (1 to HISTORY_DEPTH) one per cycle,
// start a 17 step bit-serial divide by the fill count and wait for the
// quotient, then hysteresis and the result load; the sample channel is stalled
// throughout. A prime burst ends after the store step and gives no result. The
// result sits in an output register, so samples keep flowing while it waits; a
// second burst end waits at its load step until that register frees up.
// adc_scale is always ready for writes.
module battery_voltage_filter_gauge
  import bvfg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  sample_t            sample_item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // the scale register takes a write in any cycle
  assign cfg_ready = 1'b1;

  bvfg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  bvfg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_item  (sample_item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

/* design/bvfg_div.sv */
// Restoring divider, one quotient bit per cycle, for the ring average.
// Depends on bvfg_pkg.
module bvfg_div
  import bvfg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             busy,
  output logic [ACC_W-1:0] quotient
);

  localparam int REM_W = LEN_W + 1;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem_shift;
  logic             ge;

  // shift in the next dividend bit and try a subtract
  assign rem_shift = {rem[REM_W-2:0], quotient[ACC_W-1]};
  assign ge        = (rem_shift >= REM_W'(divisor));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ACC_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? (rem_shift - REM_W'(divisor)) : rem_shift;
      quotient <= {quotient[ACC_W-2:0], ge};
    end
  end

`ifndef SYNTH
  a_start_busy : assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> rem < REM_W'(divisor))
    else $error("divider remainder out of range");
  a_no_restart : assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
`endif

endmodule

/* design/bvfg_datapath.sv */
// Datapath: burst accumulator, scaling, history ring, ring average, hysteresis, result register.
// Depends on bvfg_pkg and bvfg_div.
module bvfg_datapath
  import bvfg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  sample_t            sample_item,
  input  logic               cfg_write,
  input  logic [SCALE_W-1:0] cfg_data,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result_item
);

  logic [SCALE_W-1:0]  adc_scale;
  logic [BSUM_W-1:0]   burst_sum;
  logic [BCNT_W-1:0]   burst_count;
  logic [BSUM_W-1:0]   burst_total;
  logic [SAMPLE_W-1:0] avg;
  logic                kind;
  logic [PROD_W-1:0]   prod;
  logic [SCALE_W-1:0]  mv_raw;
  logic [MV_W-1:0]     mv_clamped;
  logic [MV_W-1:0]     history [HISTORY_DEPTH];
  logic [SLOT_W-1:0]   write_slot;
  logic                history_full;
  logic                slot_wrap;
  logic [LEN_W-1:0]    sum_len;
  logic [SLOT_W-1:0]   idx;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    quotient;
  logic                div_busy;
  logic [MV_W-1:0]     filtered;
  logic [MV_W-1:0]     diff;
  logic [MV_W-1:0]     held_mv;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_scale <= ADC_SCALE_RST;
    end else if (cfg_write) begin
      adc_scale <= cfg_data;
    end
  end

  // burst accumulation
  assign burst_total = burst_sum + BSUM_W'(sample_item.sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_sum   <= '0;
      burst_count <= '0;
    end else if (cmd.take) begin
      if (status.burst_last) begin
        burst_sum   <= '0;
        burst_count <= '0;
      end else begin
        burst_sum   <= burst_total;
        burst_count <= burst_count + BCNT_W'(1);
      end
    end
  end

  // capture the burst average and the deciding kind
  always_ff @(posedge clk) begin
    if (cmd.take && status.burst_last) begin
      avg  <= SAMPLE_W'(burst_total / SAMPLES_PER_BURST);
      kind <= sample_item.kind;
    end
  end

  // scale to millivolts
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod <= {{SAMPLE_W{1'b0}}, adc_scale} * {{SCALE_W{1'b0}}, avg};
    end
  end

  assign mv_raw = prod[PROD_W-1:PROD_W-SCALE_W];

  // charger clamp, prime bursts always fall back to the full level
  always_comb begin
    mv_clamped = mv_raw[MV_W-1:0];
    if (mv_raw > SCALE_W'(CHARGER_MV)) begin
      if (!kind && held_mv != '0 && held_mv <= CHARGER_MV) begin
        mv_clamped = held_mv;
      end else begin
        mv_clamped = FULL_MV;
      end
    end
  end

  assign slot_wrap = (write_slot == SLOT_W'(HISTORY_DEPTH - 1));

  // ring write: prime fills every entry, measure writes one slot
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (kind) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          history[i] <= mv_clamped;
        end
      end else begin
        history[write_slot] <= mv_clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      history_full <= 1'b0;
    end else if (cmd.store) begin
      if (kind) begin
        history_full <= 1'b1;
      end else begin
        write_slot <= slot_wrap ? '0 : write_slot + SLOT_W'(1);
        if (slot_wrap) begin
          history_full <= 1'b1;
        end
      end
    end
  end

  // walk the filled part of the ring, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      sum_len <= (history_full || slot_wrap) ? LEN_W'(HISTORY_DEPTH)
                                             : LEN_W'(write_slot) + LEN_W'(1);
      idx     <= '0;
      acc     <= '0;
    end else if (cmd.sum_step) begin
      acc <= acc + ACC_W'(history[idx]);
      idx <= idx + SLOT_W'(1);
    end
  end

  bvfg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc),
    .divisor  (sum_len),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // hysteresis on the reported value
  assign filtered = quotient[MV_W-1:0];
  assign diff     = (filtered > held_mv) ? filtered - held_mv : held_mv - filtered;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mv <= '0;
    end else if (cmd.store && kind) begin
      held_mv <= mv_clamped;
    end else if (cmd.hyst && (held_mv == '0 || diff > HYST_MV)) begin
      held_mv <= filtered;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_item.reported_mv <= held_mv;
      result_item.percent     <= lipo_percent(held_mv);
    end
  end

  // status back to the controller
  assign status.burst_last = (burst_count == BCNT_W'(SAMPLES_PER_BURST - 1));
  assign status.prime      = kind;
  assign status.sum_last   = ((LEN_W'(idx) + LEN_W'(1)) == sum_len);
  assign status.div_busy   = div_busy;
  assign status.out_free   = !result_valid || !result_stall;

`ifndef SYNTH
  a_held_range : assert property (@(posedge clk) disable iff (rst) held_mv <= CHARGER_MV)
    else $error("held value above charger level");
  a_emit_valid : assert property (@(posedge clk) disable iff (rst) cmd.emit |=> result_valid)
    else $error("result not presented after emit");
  a_len_nonzero : assert property (@(posedge clk) disable iff (rst)
    cmd.sum_step |-> sum_len != '0)
    else $error("ring walk with empty length");
  a_pct_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.percent <= PCT_FULL)
    else $error("percentage above full");
`endif

endmodule

/* design/bvfg_ctrl.sv */
// Controller: sequences burst end work (scale, store, ring walk, divide, hysteresis, emit).
// Depends on bvfg_pkg.
module bvfg_ctrl
  import bvfg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_STORE,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_HYST,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = sample_valid;
        if (sample_valid && status.burst_last) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.prime ? S_IDLE : S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_HYST;
        end
      end
      S_HYST: begin
        cmd.hyst   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample_stall = (state != S_IDLE);

`ifndef SYNTH
  a_walk_after_store : assert property (@(posedge clk) disable iff (rst)
    cmd.store && !status.prime |=> state == S_SUM)
    else $error("measure burst skipped the ring walk");
  a_emit_free : assert property (@(posedge clk) disable iff (rst) cmd.emit |-> status.out_free)
    else $error("result overwritten while held");
  a_take_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !cmd.scale && !cmd.store && !cmd.emit)
    else $error("sample taken during burst end work");
`endif

endmodule

/* dv/battery_voltage_filter_gauge_test.sv */
// Self-checking testbench for battery_voltage_filter_gauge: directed bursts, then random
// phases over several adc_scale settings, checked against an in-bench burst predictor.
// Depends on bvfg_pkg and the design files under design/.
module battery_voltage_filter_gauge_test
  import bvfg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_MEASURE  = 1'b0;
  localparam logic KIND_PRIME    = 1'b1;
  localparam int   SETTLE_CYCLES = 64;
  localparam int   HOLD_CYCLES   = 600;
  localparam int   TIMEOUT_NS    = 2_000_000;
  localparam int   PLAN_ROWS     = 15;

  typedef enum {MID_BURST, PRIME_DONE, MEASURE_DONE} burst_step_e;

  // one directed burst: all samples alternate samp_a and samp_b, last sample sets the kind
  typedef struct packed {
    logic                last_kind;
    logic                other_kind;
    logic [SAMPLE_W-1:0] samp_a;
    logic [SAMPLE_W-1:0] samp_b;
    bit                  typed;
    int                  want_mv;
    int                  want_pct;
  } plan_row_t;

  typedef struct packed {
    bit      typed;
    result_t want;
  } typed_expect_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  sample_t            sample_item;
  logic               result_valid;
  logic               result_stall;
  result_t            result_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SCALE_W-1:0] cfg_data;

  // predictor state
  int unsigned scale_q;
  int unsigned acc_sum;
  int unsigned acc_count;
  int unsigned ring [HISTORY_DEPTH];
  int unsigned ring_slot;
  bit          ring_full;
  int unsigned held_q;

  result_t       expected_q [$];
  typed_expect_t directed_q [$];

  // run control and bookkeeping
  bit quiet     = 1'b0;
  bit gappy     = 1'b1;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int fail_count     = 0;
  int accepted_count = 0;
  int burst_count    = 0;
  int prime_count    = 0;
  int checked_count  = 0;
  int scale_writes   = 0;
  int input_stalls   = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{KIND_MEASURE, KIND_MEASURE, 12'h000, 12'h000, 1'b1, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'hFFF, 12'hFFF, 1'b0, 0, 0},
    '{KIND_PRIME,   KIND_MEASURE, 12'hFFF, 12'hFFF, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'hFFF, 12'hFFF, 1'b1, 4200, 100},
    '{KIND_MEASURE, KIND_PRIME,   12'hAAA, 12'h555, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_PRIME,   12'h555, 12'hAAA, 1'b0, 0, 0},
    '{KIND_PRIME,   KIND_MEASURE, 12'h000, 12'h000, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_PRIME,   12'h000, 12'h000, 1'b1, 0, 0},
    '{KIND_PRIME,   KIND_PRIME,   12'h8F9, 12'h8F9, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'h8FC, 12'h8FC, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'h960, 12'h960, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'hA28, 12'hA28, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'h708, 12'h708, 1'b0, 0, 0},
    '{KIND_MEASURE, KIND_MEASURE, 12'h708, 12'h708, 1'b0, 0, 0},
    '{KIND_PRIME,   KIND_MEASURE, 12'hFFF, 12'hFFF, 1'b0, 0, 0}
  };

  battery_voltage_filter_gauge dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // piecewise lipo curve
  function automatic int unsigned charge_percent(input int unsigned mv);
    if (mv >= 4200) return 100;
    if (mv >= 4100) return 90 + (mv - 4100) / 10;
    if (mv >= 4000) return 80 + (mv - 4000) / 10;
    if (mv >= 3900) return 70 + (mv - 3900) / 10;
    if (mv >= 3800) return 60 + (mv - 3800) / 10;
    if (mv >= 3700) return 40 + (mv - 3700) / 5;
    if (mv >= 3600) return 25 + (mv - 3600) / 7;
    if (mv >= 3500) return 15 + (mv - 3500) / 10;
    if (mv >= 3400) return 8 + (mv - 3400) / 14;
    if (mv >= 3300) return 4 + (mv - 3300) / 25;
    if (mv >= 3000) return (mv - 3000) / 75;
    return 0;
  endfunction

  // burst accumulation, ring filter and hysteresis for one accepted sample
  function automatic burst_step_e absorb_sample(input sample_t s, output result_t r);
    int unsigned avg;
    int unsigned mv;
    int unsigned fill;
    int unsigned total;
    int unsigned filt;
    int unsigned gap;
    r = '0;
    acc_sum += s.sample;
    if (acc_count + 1 < SAMPLES_PER_BURST) begin
      acc_count++;
      return MID_BURST;
    end
    avg       = acc_sum / SAMPLES_PER_BURST;
    acc_sum   = 0;
    acc_count = 0;
    mv        = (scale_q * avg) / 4096;

    // prime burst floods the ring, clamping charger level to full
    if (s.kind == KIND_PRIME) begin
      if (mv > CHARGER_MV) mv = FULL_MV;
      for (int i = 0; i < HISTORY_DEPTH; i++) ring[i] = mv;
      ring_full = 1'b1;
      held_q    = mv;
      return PRIME_DONE;
    end

    // charger level falls back to the held value when there is a sane one
    if (mv > CHARGER_MV) mv = (held_q > 0 && held_q <= CHARGER_MV) ? held_q : FULL_MV;

    if (ring_slot >= HISTORY_DEPTH) ring_slot = 0;
    ring[ring_slot] = mv;
    ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
    if (ring_slot == 0) ring_full = 1'b1;

    fill  = ring_full ? HISTORY_DEPTH : ((ring_slot > 0) ? ring_slot : 1);
    total = 0;
    for (int i = 0; i < fill; i++) total += ring[i];
    filt = total / fill;

    gap = (filt > held_q) ? filt - held_q : held_q - filt;
    if (held_q == 0 || gap > HYST_MV) held_q = filt;

    r.reported_mv = MV_W'(held_q);
    r.percent     = PCT_W'(charge_percent(held_q));
    return MEASURE_DONE;
  endfunction

  // one sample transfer, with an optional random gap in front
  task automatic offer_sample(input sample_t s);
    if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= s;
    do @(posedge clk); while (sample_stall);
  endtask

  // drain all pending results, then give a trailing prime burst time to finish
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_writes++;
  endtask

  // random burst: mostly voltages in the lipo range or near the held value, some noise
  task automatic run_random_burst();
    sample_t s;
    logic    last_kind;
    int      mode;
    int      tgt;
    int      base;
    int      spread;
    int      v;
    last_kind = ($urandom_range(0, 99) < 12) ? KIND_PRIME : KIND_MEASURE;
    mode      = $urandom_range(0, 9);
    gappy     = $urandom_range(0, 1);
    spread    = 8;
    if (mode >= 5 && held_q != 0)
      tgt = int'(held_q) + int'($urandom_range(0, 160)) - 80;
    else
      tgt = int'($urandom_range(2800, 4400));
    if (scale_q == 0) base = int'($urandom_range(0, 4095));
    else base = tgt * 4096 / int'(scale_q);
    if (base > 4095) base = 4095;
    if (mode == 1) begin
      base   = $urandom_range(0, 1) ? 4095 : 0;
      spread = 0;
    end
    for (int k = 0; k < SAMPLES_PER_BURST; k++) begin
      if (mode == 0) v = int'($urandom_range(0, 4095));
      else v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      s.sample = SAMPLE_W'(v);
      if (k == SAMPLES_PER_BURST - 1) s.kind = last_kind;
      else s.kind = ($urandom_range(0, 7) == 0) ? ~last_kind : last_kind;
      offer_sample(s);
    end
  endtask

  task automatic run_phase(input logic [SCALE_W-1:0] scale, input int bursts);
    write_scale(scale);
    repeat (bursts) run_random_burst();
    settle();
  endtask

  // stimulus
  initial begin
    plan_row_t     row;
    typed_expect_t te;
    sample_t       s;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_item  = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    scale_q      = ADC_SCALE_RST;
    acc_sum      = 0;
    acc_count    = 0;
    ring_slot    = 0;
    ring_full    = 1'b0;
    held_q       = 0;
    for (int i = 0; i < HISTORY_DEPTH; i++) ring[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed bursts at the reset scale
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row                  = plan[r];
      te.typed             = row.typed;
      te.want.reported_mv  = MV_W'(row.want_mv);
      te.want.percent      = PCT_W'(row.want_pct);
      directed_q.push_back(te);
      gappy = r[0];
      for (int k = 0; k < SAMPLES_PER_BURST; k++) begin
        s.kind   = (k == SAMPLES_PER_BURST - 1) ? row.last_kind : row.other_kind;
        s.sample = k[0] ? row.samp_b : row.samp_a;
        offer_sample(s);
      end
    end
    settle();

    // random phases over several scales, the first under a long result hold-off
    hold_req = 1'b1;
    run_phase(ADC_SCALE_RST, 12);
    run_phase({SCALE_W{1'b1}}, 8);
    run_phase('0, 4);
    run_phase(SCALE_W'($urandom_range(4000, 9000)), 11);
    run_phase(SCALE_W'($urandom_range(0, 16383)), 8);
    quiet = 1'b1;
    run_phase(ADC_SCALE_RST, 14);

    $display("covered %0d samples in %0d bursts (%0d prime), %0d results checked, %0d scale writes",
             accepted_count, burst_count, prime_count, checked_count, scale_writes);
    $display("sample input stalled %0d cycles; %0d mismatches", input_stalls, fail_count);
    if (fail_count == 0) begin
      $display("** battery_voltage_filter_gauge: PASSED **");
    end else begin
      $display("** battery_voltage_filter_gauge: FAILED **");
    end
    $finish;
  end

  // result side: random stall bursts, calm stretches, one long hold-off
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // transfer monitor: predict on accepted samples, check accepted results
  always @(posedge clk) begin : watch
    burst_step_e   step;
    result_t       pred;
    result_t       want;
    typed_expect_t te;
    if (!rst) begin
      if (cfg_valid && cfg_ready) scale_q = cfg_data;
      if (sample_valid && sample_stall) input_stalls++;
      if (sample_valid && !sample_stall) begin
        accepted_count++;
        step = absorb_sample(sample_item, pred);
        if (step != MID_BURST) begin
          burst_count++;
          want = pred;
          if (directed_q.size() != 0) begin
            te = directed_q.pop_front();
            if (te.typed) want = te.want;
          end
          if (step == MEASURE_DONE) expected_q.push_back(want);
          else prime_count++;
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got mv %0d pct %0d",
                   $time, result_item.reported_mv, result_item.percent);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          checked_count++;
          if (result_item.reported_mv !== want.reported_mv) begin
            $display("%0t: reported_mv expected %0d, got %0d",
                     $time, want.reported_mv, result_item.reported_mv);
            fail_count++;
          end
          if (result_item.percent !== want.percent) begin
            $display("%0t: percent expected %0d, got %0d",
                     $time, want.percent, result_item.percent);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout at %0t with %0d results outstanding", $time, expected_q.size());
    $display("** battery_voltage_filter_gauge: FAILED **");
    $finish;
  end

endmodule

/* battery_voltage_filter_gauge.f */
design/bvfg_pkg.sv
design/bvfg_div.sv
design/bvfg_datapath.sv
design/bvfg_ctrl.sv
design/battery_voltage_filter_gauge.sv
dv/battery_voltage_filter_gauge_test.sv
